@@ sv/pge_pkg.sv @@
// pge_pkg: shared widths, register map, codes and the energy function
// for the pixel gradient energy unit; used by the interfaces and all modules
`default_nettype none

package pge_pkg;

  localparam int unsigned PIXEL_W       = 8;
  localparam int unsigned COL_CNT_W     = 11;
  localparam int unsigned LINE_CNT_W    = 16;
  localparam int unsigned MAX_COLUMNS_D = 1024;

  // apb register map, one 32-bit word per register
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic REG_COLUMN_COUNT = 1'b0;
  localparam logic REG_LINE_COUNT   = 1'b1;

  localparam logic [COL_CNT_W-1:0]  COLUMN_COUNT_RST = 11'd1024;
  localparam logic [LINE_CNT_W-1:0] LINE_COUNT_RST   = 16'd1024;

  localparam logic [PIXEL_W-1:0] ENERGY_MAX = 8'd255;

  typedef enum logic {
    OP_PIXEL = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_e;

  function automatic logic [PIXEL_W-1:0] abs_diff(input logic [PIXEL_W-1:0] a,
                                                  input logic [PIXEL_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  // saturated sum of the three absolute differences around one pixel
  function automatic logic [PIXEL_W-1:0] energy_of(input logic [PIXEL_W-1:0] here,
                                                   input logic [PIXEL_W-1:0] right,
                                                   input logic [PIXEL_W-1:0] below,
                                                   input logic [PIXEL_W-1:0] diag);
    logic [PIXEL_W+1:0] sum;
    sum = {2'b00, abs_diff(here, right)} + {2'b00, abs_diff(here, below)}
        + {2'b00, abs_diff(here, diag)};
    return (sum > {2'b00, ENERGY_MAX}) ? ENERGY_MAX : sum[PIXEL_W-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/pge_pix_if.sv @@
// pge_pix_if: pixel input channel, valid/ready with opcode and pixel
// depends on pge_pkg for the pixel width
`default_nettype none

interface pge_pix_if;
  import pge_pkg::*;

  logic               valid;
  logic               ready;
  logic               opcode;
  logic [PIXEL_W-1:0] pixel;

  modport source (output valid, output opcode, output pixel, input ready);
  modport sink   (input valid, input opcode, input pixel, output ready);
endinterface

`default_nettype wire

@@ sv/pge_nrg_if.sv @@
// pge_nrg_if: energy result channel, valid/ready with energy and end flags
// depends on pge_pkg for the energy width
`default_nettype none

interface pge_nrg_if;
  import pge_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] energy;
  logic               last_of_item;
  logic               last_of_frame;

  modport source (output valid, output energy, output last_of_item,
                  output last_of_frame, input ready);
  modport sink   (input valid, input energy, input last_of_item,
                  input last_of_frame, output ready);
endinterface

`default_nettype wire

@@ sv/pge_line_mem.sv @@
// pge_line_mem: line buffer, one write port and two registered read ports
// with write-to-read forwarding; depends on pge_pkg
`default_nettype none

module pge_line_mem #(
  parameter int unsigned DEPTH = pge_pkg::MAX_COLUMNS_D
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              we_i,
  input  wire logic [$clog2(DEPTH)-1:0]          waddr_i,
  input  wire logic [pge_pkg::PIXEL_W-1:0]       wdata_i,
  input  wire logic                              re_i,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr0_i,
  input  wire logic [$clog2(DEPTH)-1:0]          raddr1_i,
  output logic      [pge_pkg::PIXEL_W-1:0]       rdata0_o,
  output logic      [pge_pkg::PIXEL_W-1:0]       rdata1_o
);
  import pge_pkg::*;

  logic [PIXEL_W-1:0] mem [DEPTH];
  logic [PIXEL_W-1:0] rd0_q, rd1_q, fwd_data_q;
  logic               fwd0_q, fwd1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd0_q <= mem[raddr0_i];
      rd1_q <= mem[raddr1_i];
    end
    if (re_i && we_i) begin
      fwd_data_q <= wdata_i;
    end
  end

  // a read at the edge of a write to the same entry sees the new data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd0_q <= 1'b0;
      fwd1_q <= 1'b0;
    end else if (re_i) begin
      fwd0_q <= we_i && (waddr_i == raddr0_i);
      fwd1_q <= we_i && (waddr_i == raddr1_i);
    end
  end

  assign rdata0_o = fwd0_q ? fwd_data_q : rd0_q;
  assign rdata1_o = fwd1_q ? fwd_data_q : rd1_q;

endmodule

`default_nettype wire

@@ sv/pixel_gradient_energy_unit.sv @@
// pixel_gradient_energy_unit: streaming gradient energy map over a line buffer
// depends on pge_pkg, pge_pix_if, pge_nrg_if and pge_line_mem
//
//   channel   dir  transfer carries                        handshake
//   pix_i     in   opcode (pixel/flush), pixel             valid/ready
//   nrg_o     out  energy, last_of_item, last_of_frame     valid/ready
//   apb       in   column_count @0x0, line_count @0x4      psel/penable, pready=1
//
// one item per clock unless the compute stage is held: the line memory is read at
// the accepting edge, the item then sits in the compute stage, and its line memory
// write lands at the edge it leaves, forwarded to a read of the same entry at that edge.
// an item that yields two results (a line end past the first line and column)
// holds the compute stage until both results are out.
// the result register loads each result as the compute stage pushes it.
// reset initialises the control state and configuration registers; the payload
// registers and line buffer are not cleared, every entry is written in a frame
// before it is read. a stall on nrg_o holds the result register and, once the
// compute stage is full, pix_i.ready drops in the same cycle.
`default_nettype none

module pixel_gradient_energy_unit #(
  parameter int unsigned MAX_COLUMNS = pge_pkg::MAX_COLUMNS_D
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  pge_pix_if.sink                                 pix_i,
  pge_nrg_if.source                               nrg_o,
  input  wire logic                               psel,
  input  wire logic                               penable,
  input  wire logic                               pwrite,
  input  wire logic [pge_pkg::APB_ADDR_W-1:0]     paddr,
  input  wire logic [pge_pkg::APB_DATA_W-1:0]     pwdata,
  output logic      [pge_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                    pready
);
  import pge_pkg::*;

  localparam int unsigned CW    = $clog2(MAX_COLUMNS);
  localparam int unsigned CNTW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned CMPW  = (CNTW > COL_CNT_W) ? CNTW : COL_CNT_W;
  localparam logic [CMPW-1:0] MAX_C = CMPW'(MAX_COLUMNS);
  localparam logic [CMPW-1:0] ONE_C = CMPW'(1);

  // configuration registers
  logic [COL_CNT_W-1:0]  column_count_q;
  logic [LINE_CNT_W-1:0] line_count_q;

  // frame position, advanced at transfer
  logic [CW-1:0]         col_idx_q;
  logic [LINE_CNT_W-1:0] line_idx_q;
  logic                  flushing_q;

  // left neighbours, advanced when a pixel leaves the compute stage
  logic [PIXEL_W-1:0]    above_left_q, current_left_q;

  // compute stage
  logic                  s1_valid_q;
  logic                  s1_a_pend_q;   // interior result or flush result
  logic                  s1_b_pend_q;   // final column of the line above
  logic                  s1_flush_q;
  logic                  s1_last_q;     // flush of the last column
  logic                  s1_wr_q;       // pixel: write it back, move the lefts
  logic                  s1_eol_q;
  logic [PIXEL_W-1:0]    s1_pixel_q;
  logic [CW-1:0]         s1_col_q;

  // result register
  logic                  out_valid_q;
  logic [PIXEL_W-1:0]    out_energy_q;
  logic                  out_last_item_q, out_last_frame_q;

  logic [PIXEL_W-1:0]    above, right_px;
  logic                  cfg_wr, cfg_idx;
  logic [CMPW-1:0]       cc_w, last_col_w;
  logic [CW-1:0]         last_col, col_nxt;
  logic [LINE_CNT_W-1:0] lines_eff, line_nxt;
  logic                  out_load, s1_has, push, s1_done, in_ready, accept;
  logic                  is_flush, use_pix, use_flush, at_eol;
  logic [PIXEL_W-1:0]    push_energy;

  // ---------------------------------------------------------------- apb
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[APB_ADDR_W-1];

  always_comb begin
    unique case (cfg_idx)
      REG_COLUMN_COUNT: prdata = APB_DATA_W'(column_count_q);
      REG_LINE_COUNT:   prdata = APB_DATA_W'(line_count_q);
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------ effective frame size
  // column_count of zero acts as one, above the buffer as the buffer size
  assign cc_w = CMPW'(column_count_q);
  always_comb begin
    if (cc_w == '0) begin
      last_col_w = '0;
    end else if (cc_w > MAX_C) begin
      last_col_w = MAX_C - ONE_C;
    end else begin
      last_col_w = cc_w - ONE_C;
    end
  end
  assign last_col  = last_col_w[CW-1:0];
  assign lines_eff = (line_count_q == '0) ? LINE_CNT_W'(1) : line_count_q;
  assign col_nxt   = col_idx_q + CW'(1);
  assign line_nxt  = line_idx_q + LINE_CNT_W'(1);
  assign at_eol    = (col_idx_q == last_col);

  // ---------------------------------------------------------- handshake
  assign out_load = !out_valid_q || nrg_o.ready;
  assign s1_has   = s1_a_pend_q || s1_b_pend_q;
  assign push     = s1_valid_q && s1_has && out_load;
  assign s1_done  = s1_valid_q && (!s1_has || (push && !(s1_a_pend_q && s1_b_pend_q)));
  assign in_ready = !s1_valid_q || s1_done;
  assign accept   = pix_i.valid && in_ready;

  assign pix_i.ready = in_ready;

  // early flushes and pixels during the flush phase are taken and dropped
  assign is_flush  = (pix_i.opcode == OP_FLUSH);
  assign use_pix   = accept && !is_flush && !flushing_q;
  assign use_flush = accept && is_flush && flushing_q;

  // --------------------------------------------------------- line buffer
  pge_line_mem #(
    .DEPTH(MAX_COLUMNS)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_i     (s1_done && s1_wr_q),
    .waddr_i  (s1_col_q),
    .wdata_i  (s1_pixel_q),
    .re_i     (accept),
    .raddr0_i (col_idx_q),
    .raddr1_i (col_nxt),
    .rdata0_o (above),
    .rdata1_o (right_px)
  );

  // ------------------------------------------------------- result select
  // flush: last line against zero below; a: pixel one up and one left;
  // b: last column of the line above
  always_comb begin
    if (s1_flush_q) begin
      push_energy = energy_of(above, s1_last_q ? '0 : right_px, '0, '0);
    end else if (s1_a_pend_q) begin
      push_energy = energy_of(above_left_q, above, current_left_q, s1_pixel_q);
    end else begin
      push_energy = energy_of(above, '0, s1_pixel_q, '0);
    end
  end

  // ------------------------------------------------ control and pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= COLUMN_COUNT_RST;
      line_count_q   <= LINE_COUNT_RST;
      col_idx_q      <= '0;
      line_idx_q     <= '0;
      flushing_q     <= 1'b0;
      above_left_q   <= '0;
      current_left_q <= '0;
      s1_valid_q     <= 1'b0;
      s1_a_pend_q    <= 1'b0;
      s1_b_pend_q    <= 1'b0;
      s1_flush_q     <= 1'b0;
      s1_last_q      <= 1'b0;
      s1_wr_q        <= 1'b0;
      s1_eol_q       <= 1'b0;
      out_valid_q    <= 1'b0;
    end else if (cfg_wr) begin
      // any write restarts the frame; user must keep the block idle (unenforced)
      unique case (cfg_idx)
        REG_COLUMN_COUNT: column_count_q <= pwdata[COL_CNT_W-1:0];
        REG_LINE_COUNT:   line_count_q   <= pwdata[LINE_CNT_W-1:0];
        default: ;
      endcase
      col_idx_q      <= '0;
      line_idx_q     <= '0;
      flushing_q     <= 1'b0;
      above_left_q   <= '0;
      current_left_q <= '0;
    end else begin
      // frame position
      if (use_pix) begin
        if (at_eol) begin
          col_idx_q <= '0;
          if (line_nxt == '0 || line_nxt >= lines_eff) begin
            line_idx_q <= '0;
            flushing_q <= 1'b1;
          end else begin
            line_idx_q <= line_nxt;
          end
        end else begin
          col_idx_q <= col_nxt;
        end
      end else if (use_flush) begin
        if (at_eol) begin
          col_idx_q  <= '0;
          flushing_q <= 1'b0;
        end else begin
          col_idx_q <= col_nxt;
        end
      end

      // left neighbours move on as a pixel leaves the compute stage
      if (s1_done && s1_wr_q) begin
        if (s1_eol_q) begin
          above_left_q   <= '0;
          current_left_q <= '0;
        end else begin
          above_left_q   <= above;
          current_left_q <= s1_pixel_q;
        end
      end

      // compute stage
      if (in_ready) begin
        s1_valid_q  <= use_pix || use_flush;
        s1_flush_q  <= use_flush;
        s1_wr_q     <= use_pix;
        s1_eol_q    <= at_eol;
        s1_last_q   <= at_eol;
        s1_a_pend_q <= use_flush || (use_pix && line_idx_q != '0 && col_idx_q != '0);
        s1_b_pend_q <= use_pix && line_idx_q != '0 && at_eol;
      end else if (push) begin
        if (s1_a_pend_q) begin
          s1_a_pend_q <= 1'b0;
        end else begin
          s1_b_pend_q <= 1'b0;
        end
      end

      // result register
      if (out_load) begin
        out_valid_q <= push;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_pixel_q <= pix_i.pixel;
      s1_col_q   <= col_idx_q;
    end
    if (push) begin
      out_energy_q     <= push_energy;
      out_last_item_q  <= !(s1_a_pend_q && s1_b_pend_q);
      out_last_frame_q <= s1_flush_q && s1_last_q;
    end
  end

  assign nrg_o.valid         = out_valid_q;
  assign nrg_o.energy        = out_energy_q;
  assign nrg_o.last_of_item  = out_last_item_q;
  assign nrg_o.last_of_frame = out_last_frame_q;

endmodule

`default_nettype wire
